>>> rtl/core/lad_pkg.sv
// Shared types, constants and codes for the line area downscaler.
package lad_pkg;

    // Sample precision actually used out of the 16-bit sample field
    localparam int SAMPLE_BITS = 16;
    localparam int FIELD_W     = 16;
    localparam int RES_W       = 14;
    localparam int CARRY_W     = 15;
    localparam int PSUM_W      = 32;
    localparam int WT_W        = 17;
    localparam int PROD_W      = SAMPLE_BITS + 1 + WT_W;
    localparam int NUM_W       = ((PROD_W > PSUM_W) ? PROD_W : (PSUM_W + 1)) + 1;
    localparam int CNT_W       = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

    // Config port geometry
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // Register indexes
    localparam logic [1:0] REG_SRC   = 2'd0;
    localparam logic [1:0] REG_TGT   = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;

    // Reset values of the registers
    localparam logic [RES_W-1:0]   SRC_RESET   = RES_W'(600);
    localparam logic [RES_W-1:0]   TGT_RESET   = RES_W'(600);
    localparam logic [FIELD_W-1:0] WIDTH_RESET = '0;

    // Item function codes
    localparam logic [1:0] FUNC_NEXT   = 2'd0;
    localparam logic [1:0] FUNC_LINE   = 2'd1;
    localparam logic [1:0] FUNC_REPEAT = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ACCUM,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_PUSH,
        S_PUSH_ERR
    } t_lad_state;

    typedef struct packed {
        logic [RES_W-1:0]   src;
        logic [RES_W-1:0]   tgt;
        logic [FIELD_W-1:0] width;
    } t_lad_cfg;

    // Controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic line_clear;
        logic take_sample;
        logic accum;
        logic split;
        logic mul;
        logic div_init;
        logic div_step;
        logic push_val;
        logic push_err;
    } t_lad_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic ignore;
        logic err;
        logic skip;
        logic carry_lt;
        logic div_direct;
        logic out_free;
    } t_lad_sts;

endpackage

>>> rtl/core/lad_if.sv
// Item channel interfaces: input items and result items.
interface lad_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink   (input valid, input func, input sample, output ready);
endinterface

interface lad_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;
    logic [15:0] position;
    logic        line_done;
    logic        error;

    modport source (output valid, output value, output position, output line_done,
                    output error, input ready);
    modport sink   (input valid, input value, input position, input line_done,
                    input error, output ready);
endinterface

>>> rtl/core/lad_cfg_regs.sv
// APB-style configuration registers: resolutions and output width.
module lad_cfg_regs import lad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_lad_cfg          o_cfg
);

    logic [RES_W-1:0]   r_src;
    logic [RES_W-1:0]   r_tgt;
    logic [FIELD_W-1:0] r_width;
    logic [1:0]         reg_idx;
    logic               wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src   <= SRC_RESET;
            r_tgt   <= TGT_RESET;
            r_width <= WIDTH_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SRC:   r_src   <= pwdata[RES_W-1:0];
                REG_TGT:   r_tgt   <= pwdata[RES_W-1:0];
                REG_WIDTH: r_width <= pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_SRC:   prdata = DATA_W'(r_src);
            REG_TGT:   prdata = DATA_W'(r_tgt);
            REG_WIDTH: prdata = DATA_W'(r_width);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg = '{src: r_src, tgt: r_tgt, width: r_width};

endmodule

>>> rtl/core/lad_ctrl.sv
// Sequencer: walks one item through decode, accumulate, multiply, divide and push.
module lad_ctrl import lad_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_lad_sts i_sts,
    output t_lad_cmd o_cmd
);

    t_lad_state       r_state;
    t_lad_state       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_sts.ignore) begin
                    n_state = S_IDLE;
                end else if (i_sts.err) begin
                    n_state = S_PUSH_ERR;
                end else if (i_sts.skip) begin
                    o_cmd.line_clear = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.line_clear  = 1'b1;
                    o_cmd.take_sample = 1'b1;
                    n_state           = S_ACCUM;
                end
            end
            S_ACCUM: begin
                if (i_sts.carry_lt) begin
                    o_cmd.accum = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    o_cmd.split = 1'b1;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = i_sts.div_direct ? S_PUSH : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SAMPLE_BITS - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push_val = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_PUSH_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.push_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands other than line_clear and take_sample never overlap
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.latch_in, o_cmd.accum, o_cmd.split, o_cmd.mul, o_cmd.div_init,
                  o_cmd.div_step, o_cmd.push_val, o_cmd.push_err}))
        else $error("overlapping datapath commands");

    // An accepted item is decoded in the next cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    // The divider runs exactly SAMPLE_BITS steps before pushing
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_W'(SAMPLE_BITS - 1)) |=> (r_state == S_PUSH))
        else $error("divider step count wrong");

endmodule

>>> rtl/core/lad_dpath.sv
// Datapath: line state, weighted accumulation, radix-2 divider and output register.
module lad_dpath import lad_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lad_cfg           i_cfg,
    input  t_lad_cmd           i_cmd,
    output t_lad_sts           o_sts,
    input  logic [1:0]         i_func,
    input  logic [FIELD_W-1:0] i_sample,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [FIELD_W-1:0] o_value,
    output logic [FIELD_W-1:0] o_position,
    output logic               o_line_done,
    output logic               o_error
);

    // Captured item
    logic [1:0]             r_func;
    logic [SAMPLE_BITS-1:0] r_smp;

    // Line state
    logic [PSUM_W-1:0]      r_psum;
    logic [CARRY_W-1:0]     r_phase;
    logic [FIELD_W-1:0]     r_count;
    logic [SAMPLE_BITS-1:0] r_held;
    logic                   r_have;

    // Working registers
    logic [SAMPLE_BITS-1:0] r_s;
    logic [CARRY_W-1:0]     r_carry;
    logic [CARRY_W-1:0]     r_over;
    logic signed [WT_W-1:0] r_wt;
    logic signed [NUM_W-1:0] r_num;
    logic [RES_W-1:0]       r_rem;
    logic [SAMPLE_BITS-1:0] r_dq;

    // Output register
    logic                   r_out_valid;
    logic [FIELD_W-1:0]     r_out_value;
    logic [FIELD_W-1:0]     r_out_pos;
    logic                   r_out_done;
    logic                   r_out_err;

    logic                          cfg_bad;
    logic [SAMPLE_BITS-1:0]        sel_s;
    logic [CARRY_W-1:0]            base_phase;
    logic [CARRY_W-1:0]            next_carry;
    logic [CARRY_W-1:0]            over;
    logic [SAMPLE_BITS+RES_W-1:0]  prod_acc;
    logic [SAMPLE_BITS+CARRY_W-1:0] prod_over;
    logic signed [PROD_W-1:0]      prod_num;
    logic signed [NUM_W-1:0]       num;
    logic                          num_neg;
    logic                          num_sat;
    logic [RES_W:0]                rem_sh;
    logic                          q_bit;
    logic [RES_W:0]                rem_sub;
    logic                          push;

    // Status toward the sequencer
    assign cfg_bad = (i_cfg.src == '0) || (i_cfg.tgt == '0) || (i_cfg.tgt > i_cfg.src);
    assign num_neg = r_num[NUM_W-1];
    assign num_sat = r_num[NUM_W-2:0] >= (NUM_W-1)'({i_cfg.src, {SAMPLE_BITS{1'b0}}});

    always_comb begin
        o_sts.ignore     = (r_func == FUNC_NONE);
        o_sts.err        = cfg_bad || ((r_func == FUNC_REPEAT) && !r_have);
        o_sts.skip       = (r_func == FUNC_LINE) ? (i_cfg.width == '0)
                                                 : (r_count >= i_cfg.width);
        o_sts.carry_lt   = r_carry < CARRY_W'(i_cfg.src);
        o_sts.div_direct = num_neg || num_sat;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // Sample select and carry advance
    assign sel_s      = (r_func == FUNC_REPEAT) ? r_held : r_smp;
    assign base_phase = (r_func == FUNC_LINE) ? '0 : r_phase;
    assign next_carry = base_phase + CARRY_W'(i_cfg.tgt);
    assign over       = r_carry - CARRY_W'(i_cfg.src);

    // Products
    assign prod_acc  = r_s * i_cfg.tgt;
    assign prod_over = r_s * r_over;
    assign prod_num  = $signed({1'b0, r_s}) * r_wt;
    assign num       = {{(NUM_W-PROD_W){prod_num[PROD_W-1]}}, prod_num}
                     + $signed({{(NUM_W-PSUM_W){1'b0}}, r_psum});

    // One restoring divide step
    assign rem_sh  = {r_rem, r_dq[SAMPLE_BITS-1]};
    assign rem_sub = rem_sh - {1'b0, i_cfg.src};
    assign q_bit   = rem_sh >= {1'b0, i_cfg.src};

    assign push = i_cmd.push_val || i_cmd.push_err;

    // Item capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func <= i_func;
            r_smp  <= i_sample[SAMPLE_BITS-1:0];
        end
        if (i_cmd.take_sample) begin
            r_s     <= sel_s;
            r_carry <= next_carry;
        end
        if (i_cmd.split) begin
            r_over <= over;
            r_wt   <= $signed({{(WT_W-RES_W){1'b0}}, i_cfg.tgt})
                    - $signed({{(WT_W-CARRY_W){1'b0}}, over});
        end
        if (i_cmd.mul) begin
            r_num <= num;
        end
        if (i_cmd.div_init) begin
            priority if (num_neg) begin
                r_dq <= '0;
            end else if (num_sat) begin
                r_dq <= '1;
            end else begin
                r_rem <= r_num[SAMPLE_BITS+RES_W-1:SAMPLE_BITS];
                r_dq  <= r_num[SAMPLE_BITS-1:0];
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_sub[RES_W-1:0] : rem_sh[RES_W-1:0];
            r_dq  <= {r_dq[SAMPLE_BITS-2:0], q_bit};
        end
    end

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum  <= '0;
            r_phase <= '0;
            r_count <= '0;
            r_held  <= '0;
            r_have  <= 1'b0;
        end else begin
            if (i_cmd.line_clear && (r_func == FUNC_LINE)) begin
                r_psum  <= '0;
                r_phase <= '0;
                r_count <= '0;
                r_have  <= 1'b0;
            end
            if (i_cmd.take_sample) begin
                r_held <= sel_s;
                r_have <= 1'b1;
            end
            if (i_cmd.accum) begin
                r_psum  <= r_psum + PSUM_W'(prod_acc);
                r_phase <= r_carry;
            end
            if (i_cmd.split) begin
                r_phase <= over;
            end
            if (i_cmd.mul) begin
                r_psum <= PSUM_W'(prod_over);
            end
            if (i_cmd.push_val) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_val) begin
            r_out_value <= FIELD_W'(r_dq);
            r_out_pos   <= r_count;
            r_out_done  <= ({1'b0, r_count} + 1'b1) == {1'b0, i_cfg.width};
            r_out_err   <= 1'b0;
        end else if (i_cmd.push_err) begin
            r_out_value <= '0;
            r_out_pos   <= r_count;
            r_out_done  <= 1'b0;
            r_out_err   <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_position  = r_out_pos;
    assign o_line_done = r_out_done;
    assign o_error     = r_out_err;

    // Error results carry a zero value and never end a line
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_value == '0 && !r_out_done))
        else $error("error result with payload");

    // A value is only pushed while the line still has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_val |-> (r_count < i_cfg.width))
        else $error("result pushed past output width");

    // A push only lands in a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> o_sts.out_free)
        else $error("push into occupied output register");

endmodule

>>> rtl/core/line_area_downscale.sv
// Line area-averaging downscaler top level: config registers, sequencer and datapath.
//
// Area-averaging horizontal downscaler for one scan line. Items are taken one at a
// time. An item that yields no result passes through accept, decode and accumulate.
// An ignored or skipped item passes through accept and decode, and an error item
// through accept, decode and the error push. An item that closes an output sample
// also passes through multiply, divider setup, the radix-2 divider that retires one
// quotient bit per cycle over 16 steps, and push; the divider steps are skipped when
// the quotient saturates or is negative. A result or error item also waits in its
// push state for as long as the previous result still sits unread in the output
// register. A finished result sits in that register, so the next item is taken
// while the result waits to be read. Configuration is written over the APB port
// at byte addresses 0 (source resolution), 4 (target resolution) and 8 (output
// width); the user must write it only while the block is idle (not enforced).
module line_area_downscale import lad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lad_in_if.sink            i_in,
    lad_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_lad_cfg cfg;
    t_lad_cmd cmd;
    t_lad_sts sts;

    lad_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lad_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_in.func),
        .i_sample    (i_in.sample),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_value     (o_out.value),
        .o_position  (o_out.position),
        .o_line_done (o_out.line_done),
        .o_error     (o_out.error)
    );

endmodule

>>> dv/line_area_downscale_checker.sv
// Checker for the line area downscaler: watches the item channels, predicts, compares.
module line_area_downscale_checker import lad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lad_in_if                 i_in_ch,
    lad_out_if                i_out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                o_fail_count,
    output int                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] position;
        logic        line_done;
        logic        error;
    } t_scaled_px;

    localparam logic [15:0] PX_MAX = 16'((32'd1 << SAMPLE_BITS) - 1);

    // Register copies
    logic [RES_W-1:0]   cfg_src;
    logic [RES_W-1:0]   cfg_tgt;
    logic [FIELD_W-1:0] cfg_width;

    // Line state of the predictor
    logic [31:0]  acc_sum;
    logic [14:0]  carry_pos;
    logic [15:0]  px_count;
    logic [15:0]  last_px;
    logic         px_seen;

    t_scaled_px awaited_px[$];
    int         mismatches;

    // Advance the line state by one item; returns 1 when an output sample or an error result is due
    function automatic bit downscale_step(input logic [1:0] f, input logic [15:0] pix_in,
                                          output t_scaled_px px);
        logic [15:0] pix;
        logic [14:0] carry_nxt;
        logic [14:0] over;
        longint      pix_l, src_l, tgt_l, over_l, num, quo;
        px = '0;
        if (f == FUNC_NONE)
            return 1'b0;
        // bad resolutions or a repeat before any sample: error, state untouched
        if (cfg_src == '0 || cfg_tgt == '0 || cfg_tgt > cfg_src ||
            (f == FUNC_REPEAT && !px_seen)) begin
            px.position = px_count;
            px.error    = 1'b1;
            return 1'b1;
        end
        if (f == FUNC_LINE) begin
            acc_sum   = '0;
            carry_pos = '0;
            px_count  = '0;
            px_seen   = 1'b0;
        end
        // line already complete
        if (px_count >= cfg_width)
            return 1'b0;
        pix     = (f == FUNC_REPEAT) ? last_px : (pix_in & PX_MAX);
        last_px = pix;
        px_seen = 1'b1;
        carry_nxt = carry_pos + cfg_tgt;
        if (carry_nxt < cfg_src) begin
            acc_sum   = acc_sum + pix * cfg_tgt;
            carry_pos = carry_nxt;
            return 1'b0;
        end
        // split the weight at the output boundary; weight may go negative mid-line
        over   = carry_nxt - cfg_src;
        pix_l  = pix;
        src_l  = cfg_src;
        tgt_l  = cfg_tgt;
        over_l = over;
        num    = pix_l * (tgt_l - over_l) + longint'({32'd0, acc_sum});
        quo    = num / src_l;
        if (quo < 0)
            quo = 0;
        if (quo > longint'(PX_MAX))
            quo = longint'(PX_MAX);
        px.value     = quo[15:0];
        px.position  = px_count;
        px.line_done = ({1'b0, px_count} + 17'd1 == {1'b0, cfg_width});
        acc_sum   = pix * over;
        carry_pos = over;
        px_count  = px_count + 16'd1;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_scaled_px want;
        t_scaled_px got;
        t_scaled_px nxt;
        if (!i_rst_n) begin
            cfg_src    = SRC_RESET;
            cfg_tgt    = TGT_RESET;
            cfg_width  = WIDTH_RESET;
            acc_sum    = '0;
            carry_pos  = '0;
            px_count   = '0;
            last_px    = '0;
            px_seen    = 1'b0;
            mismatches = 0;
            awaited_px.delete();
        end else begin
            // result side first: its expectation was queued at an earlier edge
            if (i_out_ch.valid && i_out_ch.ready) begin
                got = '{i_out_ch.value, i_out_ch.position, i_out_ch.line_done,
                        i_out_ch.error};
                if (awaited_px.size() == 0) begin
                    $error("unexpected result: value 0x%0h position %0d", got.value,
                           got.position);
                    mismatches++;
                end else begin
                    want = awaited_px.pop_front();
                    check_field("value", want.value, got.value);
                    check_field("position", want.position, got.position);
                    check_field("line_done", want.line_done, got.line_done);
                    check_field("error", want.error, got.error);
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (downscale_step(i_in_ch.func, i_in_ch.sample, nxt))
                    awaited_px.push_back(nxt);
            end
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SRC:   cfg_src   = pwdata[RES_W-1:0];
                    REG_TGT:   cfg_tgt   = pwdata[RES_W-1:0];
                    REG_WIDTH: cfg_width = pwdata[FIELD_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= awaited_px.size();
    end

endmodule

>>> dv/line_area_downscale_test.sv
// Testbench top for the line area downscaler: clock, reset, stimulus and verdict.
module line_area_downscale_test import lad_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE       = 30;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 650;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int outstanding;
    int cycle_count = 0;

    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_req  = 1'b0;

    lad_in_if  in_ch();
    lad_out_if out_ch();

    line_area_downscale uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    line_area_downscale_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_ch       (in_ch),
        .i_out_ch      (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #6 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Idle stretch: mostly short, a few long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 94)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pixel values lean on the extremes
    function automatic logic [15:0] pick_px();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'h0000;
        else if (r < 30)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Offer one item, wait for it to be taken, then maybe go idle
    task automatic offer_px(input logic [1:0] f, input logic [15:0] pix);
        int gap;
        in_ch.valid  <= 1'b1;
        in_ch.func   <= f;
        in_ch.sample <= pix;
        do @(posedge i_clk); while (!in_ch.ready);
        gap = (tx_steady || $urandom_range(0, 99) < 50) ? 0 : idle_span();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every awaited result, then let the block go idle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One write: setup, access, then an idle state on the bus
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_scaler(input int src, input int tgt, input int width);
        drain_results();
        write_reg(REG_SRC, 32'(src));
        write_reg(REG_TGT, 32'(tgt));
        write_reg(REG_WIDTH, 32'(width));
    endtask

    // One run of mostly well-formed line traffic
    task automatic stream_phase(input int n);
        int done_n;
        int r;
        done_n = 0;
        if ($urandom_range(0, 9) != 0) begin
            offer_px(FUNC_LINE, pick_px());
            done_n++;
        end
        while (done_n < n) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                offer_px(FUNC_NONE, 16'($urandom));
            end else begin
                if (r < 11)
                    offer_px(FUNC_LINE, pick_px());
                else if (r < 25)
                    offer_px(FUNC_REPEAT, 16'($urandom));
                else
                    offer_px(FUNC_NEXT, pick_px());
                done_n++;
            end
        end
    endtask

    // Result receiver: random stalls, a long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (rx_steady || $urandom_range(0, 99) < 60) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b0;
                repeat (idle_span()) @(posedge i_clk);
            end
        end
    end

    // Main stimulus
    initial begin
        int sent;
        int n;
        int r;
        int src;
        int tgt;
        int width;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.func   <= FUNC_NEXT;
        in_ch.sample <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: repeat with no sample, unused code, empty line width
        offer_px(FUNC_REPEAT, 16'hFFFF);
        offer_px(FUNC_NONE, 16'hFFFF);
        offer_px(FUNC_LINE, 16'h1234);
        offer_px(FUNC_REPEAT, 16'h0000);
        // zero source resolution
        program_scaler(0, 600, 65535);
        offer_px(FUNC_NEXT, 16'hFFFF);
        // unity ratio at the top resolution
        program_scaler(16383, 16383, 65535);
        offer_px(FUNC_LINE, 16'hFFFF);
        offer_px(FUNC_NEXT, 16'h0000);
        offer_px(FUNC_REPEAT, 16'hFFFF);
        offer_px(FUNC_NEXT, 16'hAAAA);
        offer_px(FUNC_NEXT, 16'h5555);
        // target above source: error, the line is not cleared
        program_scaler(100, 16383, 2);
        offer_px(FUNC_LINE, 16'h0007);
        // zero target resolution
        program_scaler(3, 0, 0);
        offer_px(FUNC_NEXT, 16'h0001);
        // 3:1 with two results per line, then the line is complete
        program_scaler(3, 1, 2);
        offer_px(FUNC_LINE, 16'hFFFF);
        offer_px(FUNC_NEXT, 16'hFFFF);
        offer_px(FUNC_NEXT, 16'hFFFF);
        offer_px(FUNC_REPEAT, 16'h0000);
        offer_px(FUNC_REPEAT, 16'h0000);
        offer_px(FUNC_REPEAT, 16'h0000);
        offer_px(FUNC_NEXT, 16'h0001);
        offer_px(FUNC_NONE, 16'h0000);
        // resolution change mid-line: quotient saturates high
        program_scaler(16000, 8000, 8);
        offer_px(FUNC_LINE, 16'hFFFF);
        program_scaler(1, 1, 8);
        offer_px(FUNC_NEXT, 16'h0000);
        // resolution change mid-line: weight goes negative, clamps to zero
        program_scaler(7, 5, 8);
        offer_px(FUNC_LINE, 16'h0000);
        program_scaler(4, 1, 8);
        offer_px(FUNC_NEXT, 16'hFFFF);

        // back-pressure: receiver holds off while items keep coming
        program_scaler(9, 9, 65535);
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        offer_px(FUNC_LINE, pick_px());
        repeat (23) offer_px(FUNC_NEXT, pick_px());
        tx_steady = 1'b0;

        // random phases with fresh settings each
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                case ($urandom_range(0, 2))
                    0: begin
                        src = 0;
                        tgt = $urandom_range(1, 16383);
                    end
                    1: begin
                        src = $urandom_range(1, 16383);
                        tgt = 0;
                    end
                    default: begin
                        src = $urandom_range(1, 16382);
                        tgt = $urandom_range(src + 1, 16383);
                    end
                endcase
            end else if (r < 14) begin
                src = 16383 - $urandom_range(0, 16);
                tgt = $urandom_range(src / 2, src);
            end else begin
                src = $urandom_range(1, 24);
                tgt = $urandom_range(1, src);
            end
            r = $urandom_range(0, 99);
            if (r < 70)
                width = $urandom_range(1, 12);
            else if (r < 90)
                width = $urandom_range(13, 300);
            else
                width = 65535;
            program_scaler(src, tgt, width);
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            n = $urandom_range(30, 50);
            stream_phase(n);
            sent += n;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        drain_results();
        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lad_pkg.sv
rtl/core/lad_if.sv
rtl/core/lad_cfg_regs.sv
rtl/core/lad_ctrl.sv
rtl/core/lad_dpath.sv
rtl/core/line_area_downscale.sv
dv/line_area_downscale_checker.sv
dv/line_area_downscale_test.sv
